// ----- hw/rtl/label_standardize_or_rescale_unit_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the label standardise / rescale unit
// Shared shorthand for the concurrent checks in the RTL.
// ---------------------------------------------------------------------------
`ifndef LABEL_STANDARDIZE_OR_RESCALE_UNIT_DEFINES_SVH
`define LABEL_STANDARDIZE_OR_RESCALE_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LSR_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lsr assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define LSR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lsr assertion failed");

`endif

// ----- hw/rtl/lsr_pkg.sv -----
// ---------------------------------------------------------------------------
// lsr_pkg
// Types and constants shared by the label standardise / rescale unit.
// ---------------------------------------------------------------------------
package lsr_pkg;

    localparam int DATA_W          = 32;
    localparam int IDX_W           = 6;
    localparam int SPREAD_W        = 31;
    localparam int STAT_W          = 2;
    localparam int DIVISOR_W       = 32;
    localparam int PROD_W          = 64;
    localparam int ROOT_W          = 32;
    localparam int DEF_MAX_SAMPLES = 64;
    localparam int OUT_TDATA_W     = 104;
    localparam int PADDR_W         = 4;

    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_LOWER = 2'd1;
    localparam logic [1:0] REG_UPPER = 2'd2;

    localparam logic signed [DATA_W-1:0] LOWER_RST = -32'sd65536;
    localparam logic signed [DATA_W-1:0] UPPER_RST = 32'sd65536;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_ZERO = 2'd1;
    localparam logic [STAT_W-1:0] ST_DROP = 2'd2;

    typedef struct packed {
        logic load;
        logic p1_acc;
        logic mean_go;
        logic mean_fin;
        logic diff;
        logic mul;
        logic p2_acc;
        logic var_go;
        logic sqrt_go;
        logic sqrt_fin;
        logic ediv_go;
        logic out_load;
        logic idx_clr;
        logic idx_inc;
        logic run_clr;
    } lsr_cmd_t;

    typedef struct packed {
        logic idx_last;
        logic div_done;
        logic sqrt_done;
        logic out_free;
        logic mode;
        logic zero;
    } lsr_sts_t;

endpackage

// ----- hw/rtl/lsr_div.sv -----
// ---------------------------------------------------------------------------
// lsr_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module lsr_div import lsr_pkg::*; #(
    parameter int DIV_W = 71
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [DIV_W-1:0]     dividend,
    input  logic [DIVISOR_W-1:0] divisor,
    output logic                 busy,
    output logic                 done,
    output logic [DIV_W-1:0]     quot,
    output logic [DIVISOR_W-1:0] rem
);
    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0]     dq_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] dvs_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W:0]   diff;
    logic                 ge;

    assign trial = {rem_reg, dq_reg[DIV_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            dq_reg  <= {dq_reg[DIV_W-2:0], ge};
            rem_reg <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = dq_reg;
    assign rem  = rem_reg;
endmodule

// ----- hw/rtl/lsr_sqrt.sv -----
// ---------------------------------------------------------------------------
// lsr_sqrt
// Integer square root, two radicand bits per cycle.
// ---------------------------------------------------------------------------
module lsr_sqrt import lsr_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [PROD_W-1:0] radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);
    localparam int REM_W = ROOT_W + 2;
    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [PROD_W-1:0] src_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [REM_W+1:0]  nrem;
    logic [REM_W+1:0]  trial;
    logic              ge;

    assign nrem  = {rem_reg, src_reg[PROD_W-1:PROD_W-2]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign ge    = nrem >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ROOT_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            src_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            src_reg <= {src_reg[PROD_W-3:0], 2'b00};
            if (ge) begin
                rem_reg  <= REM_W'(nrem - trial);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_reg  <= nrem[REM_W-1:0];
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule

// ----- hw/rtl/lsr_dp.sv -----
// ---------------------------------------------------------------------------
// lsr_dp
// Datapath: sample store, statistics, shared multiplier, divider and root.
// ---------------------------------------------------------------------------
`include "label_standardize_or_rescale_unit_defines.svh"

module lsr_dp import lsr_pkg::*; #(
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  lsr_cmd_t                 cmd,
    output lsr_sts_t                 sts,
    input  logic [DATA_W-1:0]        s_tdata,
    input  logic                     mode,
    input  logic signed [DATA_W-1:0] lower,
    input  logic signed [DATA_W-1:0] upper,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OUT_TDATA_W-1:0]   m_tdata,
    output logic                     m_tlast,
    output logic [STAT_W-1:0]        m_tuser
);
    localparam int ADDR_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W  = DATA_W + CNT_W;
    localparam int MN_W   = SUM_W + 2;
    localparam int ACC_W  = PROD_W + CNT_W;
    localparam int DIV_W  = ACC_W;
    localparam int T_W    = DIV_W + 2;
    localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_SAMPLES);
    localparam logic signed [T_W-1:0] SMAX = T_W'(64'sd2147483647);
    localparam logic signed [T_W-1:0] SMIN = -(T_W'(64'sd2147483648));

    logic [DATA_W-1:0] store_mem [MAX_SAMPLES];
    logic [DATA_W-1:0] rd_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              ovf_reg;
    logic [ADDR_W-1:0] idx_reg;

    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [DATA_W-1:0] min_reg, max_reg, mean_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic [DATA_W-1:0]        spread_reg;
    logic                     zero_reg;
    logic [DATA_W-1:0]        wb_reg;
    logic                     wneg_reg;
    logic [DATA_W-1:0]        mag_reg, da_reg;
    logic                     neg_reg;
    logic [PROD_W-1:0]        prod_reg;

    logic                     m_valid_reg;
    logic [DATA_W-1:0]        o_val_reg;
    logic [IDX_W-1:0]         o_idx_reg;
    logic                     o_last_reg;
    logic [DATA_W-1:0]        o_mean_reg;
    logic [SPREAD_W-1:0]      o_spread_reg;
    logic [STAT_W-1:0]        o_stat_reg;

    logic signed [DATA_W-1:0] rd_s;
    logic signed [MN_W-1:0]   mnum;
    logic                     mneg;
    logic [MN_W-1:0]          mmag;
    logic [DATA_W-1:0]        mq;
    logic [DATA_W-1:0]        mean_next;
    logic signed [DATA_W:0]   w_full, d_full, mm_full;
    logic [DIV_W-1:0]         div_dividend, e_dividend;
    logic [DIVISOR_W-1:0]     div_divisor;
    logic                     div_start, div_busy, div_done;
    logic [DIV_W-1:0]         div_q;
    logic [DIVISOR_W-1:0]     div_r;
    logic                     sqrt_done;
    logic [ROOT_W-1:0]        sqrt_root;
    logic signed [T_W-1:0]    t_base, t_q, t_sum;
    logic                     t_neg;
    logic [DATA_W-1:0]        val_next;
    logic                     out_free;

    assign rd_s = signed'(rd_reg);

    // Sample store: written while loading, read one address a cycle.
    always_ff @(posedge aclk) begin
        if (cmd.load && (cnt_reg < CAP))
            store_mem[cnt_reg[ADDR_W-1:0]] <= s_tdata;
        rd_reg <= store_mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
            idx_reg <= '0;
        end else begin
            if (cmd.load) begin
                if (cnt_reg < CAP)
                    cnt_reg <= cnt_reg + 1'b1;
                else
                    ovf_reg <= 1'b1;
            end else if (cmd.run_clr) begin
                cnt_reg <= '0;
                ovf_reg <= 1'b0;
            end
            if (cmd.idx_clr)
                idx_reg <= '0;
            else if (cmd.idx_inc)
                idx_reg <= idx_reg + 1'b1;
        end
    end

    // Mean: floor((2*sum + n) / (2*n)), sign handled around the divider.
    assign mnum = (MN_W'(sum_reg) <<< 1) + signed'(MN_W'(cnt_reg));
    assign mneg = mnum[MN_W-1];
    assign mmag = mneg ? MN_W'(-mnum) : MN_W'(mnum);
    assign mq   = div_q[DATA_W-1:0] + DATA_W'(div_r != '0);
    assign mean_next = mneg ? -mq : div_q[DATA_W-1:0];

    assign w_full  = (DATA_W+1)'(upper) - (DATA_W+1)'(lower);
    assign d_full  = (DATA_W+1)'(rd_s) - (DATA_W+1)'(mean_reg);
    assign mm_full = (DATA_W+1)'(max_reg) - (DATA_W+1)'(min_reg);

    assign e_dividend = mode
        ? DIV_W'(prod_reg) + DIV_W'(spread_reg >> 1)
        : DIV_W'({mag_reg, 16'h0000}) + DIV_W'(spread_reg >> 1);

    always_comb begin
        div_start    = cmd.mean_go || cmd.var_go || cmd.ediv_go;
        div_dividend = e_dividend;
        div_divisor  = spread_reg;
        if (cmd.mean_go) begin
            div_dividend = DIV_W'(mmag);
            div_divisor  = DIVISOR_W'({cnt_reg, 1'b0});
        end else if (cmd.var_go) begin
            div_dividend = acc_reg;
            div_divisor  = DIVISOR_W'(cnt_reg);
        end
    end

    lsr_div #(.DIV_W(DIV_W)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quot     (div_q),
        .rem      (div_r)
    );

    lsr_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.sqrt_go),
        .radicand (div_q[PROD_W-1:0]),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    always_ff @(posedge aclk) begin
        if (cmd.p1_acc) begin
            if (idx_reg == '0) begin
                sum_reg <= SUM_W'(rd_s);
                min_reg <= rd_s;
                max_reg <= rd_s;
            end else begin
                sum_reg <= sum_reg + SUM_W'(rd_s);
                if (rd_s < min_reg) min_reg <= rd_s;
                if (rd_s > max_reg) max_reg <= rd_s;
            end
        end
        if (cmd.mean_fin) begin
            mean_reg <= signed'(mean_next);
            acc_reg  <= '0;
            wneg_reg <= w_full[DATA_W];
            wb_reg   <= w_full[DATA_W] ? DATA_W'(-w_full) : w_full[DATA_W-1:0];
            if (mode) begin
                spread_reg <= mm_full[DATA_W-1:0];
                zero_reg   <= (max_reg == min_reg);
            end
        end
        if (cmd.diff) begin
            neg_reg <= d_full[DATA_W];
            mag_reg <= d_full[DATA_W] ? DATA_W'(-d_full) : d_full[DATA_W-1:0];
            da_reg  <= DATA_W'(rd_s - min_reg);
        end
        if (cmd.mul)
            prod_reg <= mode ? (PROD_W'(da_reg) * PROD_W'(wb_reg))
                             : (PROD_W'(mag_reg) * PROD_W'(mag_reg));
        if (cmd.p2_acc)
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        if (cmd.sqrt_fin) begin
            spread_reg <= sqrt_root;
            zero_reg   <= (sqrt_root == '0);
        end
    end

    // Final value: base plus or minus the rounded quotient, then clamped; zero when the spread is zero.
    assign t_neg  = mode ? wneg_reg : neg_reg;
    assign t_base = mode ? T_W'(lower) : '0;
    assign t_q    = signed'({2'b00, div_q});
    assign t_sum  = t_neg ? (t_base - t_q) : (t_base + t_q);

    always_comb begin
        if (zero_reg)
            val_next = '0;
        else if (t_sum > SMAX)
            val_next = SMAX[DATA_W-1:0];
        else if (t_sum < SMIN)
            val_next = SMIN[DATA_W-1:0];
        else
            val_next = t_sum[DATA_W-1:0];
    end

    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            o_val_reg    <= val_next;
            o_idx_reg    <= IDX_W'(idx_reg);
            o_last_reg   <= sts.idx_last;
            o_mean_reg   <= mean_reg;
            o_spread_reg <= zero_reg ? '0 :
                            (spread_reg[DATA_W-1] ? '1 : spread_reg[SPREAD_W-1:0]);
            o_stat_reg   <= zero_reg ? ST_ZERO : (ovf_reg ? ST_DROP : ST_OK);
        end
    end

    assign sts.idx_last  = (CNT_W'(idx_reg) + 1'b1) == cnt_reg;
    assign sts.div_done  = div_done;
    assign sts.sqrt_done = sqrt_done;
    assign sts.out_free  = out_free;
    assign sts.mode      = mode;
    assign sts.zero      = zero_reg;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, o_spread_reg, o_mean_reg, o_idx_reg, o_val_reg};
    assign m_tlast  = o_last_reg;
    assign m_tuser  = o_stat_reg;

    `LSR_ASSERT_SAME(a_no_overwrite, aclk, aresetn, cmd.out_load, out_free)
    `LSR_ASSERT_SAME(a_count_cap, aclk, aresetn, 1'b1, cnt_reg <= CAP)
    `LSR_ASSERT_SAME(a_div_idle, aclk, aresetn, div_start, !div_busy)
    `LSR_ASSERT_NEXT(a_run_clear, aclk, aresetn, cmd.run_clr, cnt_reg == '0 && !ovf_reg)
endmodule

// ----- hw/rtl/lsr_ctrl.sv -----
// ---------------------------------------------------------------------------
// lsr_ctrl
// Sequencer for loading, statistics passes and per-sample emission.
// ---------------------------------------------------------------------------
module lsr_ctrl import lsr_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    input  logic     s_tlast,
    output logic     s_tready,
    output lsr_cmd_t cmd,
    input  lsr_sts_t sts
);
    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_P1_RD     = 5'd1;
    localparam logic [4:0] S_P1_ACC    = 5'd2;
    localparam logic [4:0] S_MEAN      = 5'd3;
    localparam logic [4:0] S_MEAN_WAIT = 5'd4;
    localparam logic [4:0] S_MEAN_FIN  = 5'd5;
    localparam logic [4:0] S_P2_RD     = 5'd6;
    localparam logic [4:0] S_P2_DIFF   = 5'd7;
    localparam logic [4:0] S_P2_MUL    = 5'd8;
    localparam logic [4:0] S_P2_ACC    = 5'd9;
    localparam logic [4:0] S_VAR       = 5'd10;
    localparam logic [4:0] S_VAR_WAIT  = 5'd11;
    localparam logic [4:0] S_SQRT_WAIT = 5'd12;
    localparam logic [4:0] S_SQRT_FIN  = 5'd13;
    localparam logic [4:0] S_E_RD      = 5'd14;
    localparam logic [4:0] S_E_DIFF    = 5'd15;
    localparam logic [4:0] S_E_MUL     = 5'd16;
    localparam logic [4:0] S_E_DIV     = 5'd17;
    localparam logic [4:0] S_E_WAIT    = 5'd18;
    localparam logic [4:0] S_E_LOAD    = 5'd19;

    logic [4:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    if (s_tlast) begin
                        cmd.idx_clr = 1'b1;
                        state_next  = S_P1_RD;
                    end
                end
            end
            S_P1_RD: state_next = S_P1_ACC;
            S_P1_ACC: begin
                cmd.p1_acc = 1'b1;
                if (sts.idx_last) begin
                    state_next = S_MEAN;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_P1_RD;
                end
            end
            S_MEAN: begin
                cmd.mean_go = 1'b1;
                state_next  = S_MEAN_WAIT;
            end
            S_MEAN_WAIT: begin
                if (sts.div_done) state_next = S_MEAN_FIN;
            end
            S_MEAN_FIN: begin
                cmd.mean_fin = 1'b1;
                cmd.idx_clr  = 1'b1;
                state_next   = sts.mode ? S_E_RD : S_P2_RD;
            end
            S_P2_RD: state_next = S_P2_DIFF;
            S_P2_DIFF: begin
                cmd.diff   = 1'b1;
                state_next = S_P2_MUL;
            end
            S_P2_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_P2_ACC;
            end
            S_P2_ACC: begin
                cmd.p2_acc = 1'b1;
                if (sts.idx_last) begin
                    state_next = S_VAR;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_P2_RD;
                end
            end
            S_VAR: begin
                cmd.var_go = 1'b1;
                state_next = S_VAR_WAIT;
            end
            S_VAR_WAIT: begin
                if (sts.div_done) begin
                    cmd.sqrt_go = 1'b1;
                    state_next  = S_SQRT_WAIT;
                end
            end
            S_SQRT_WAIT: begin
                if (sts.sqrt_done) state_next = S_SQRT_FIN;
            end
            S_SQRT_FIN: begin
                cmd.sqrt_fin = 1'b1;
                cmd.idx_clr  = 1'b1;
                state_next   = S_E_RD;
            end
            S_E_RD: state_next = S_E_DIFF;
            S_E_DIFF: begin
                cmd.diff   = 1'b1;
                state_next = S_E_MUL;
            end
            S_E_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_E_DIV;
            end
            S_E_DIV: begin
                if (sts.zero) begin
                    state_next = S_E_LOAD;
                end else begin
                    cmd.ediv_go = 1'b1;
                    state_next  = S_E_WAIT;
                end
            end
            S_E_WAIT: begin
                if (sts.div_done) state_next = S_E_LOAD;
            end
            S_E_LOAD: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    if (sts.idx_last) begin
                        cmd.run_clr = 1'b1;
                        state_next  = S_IDLE;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_E_RD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule

// ----- hw/rtl/label_standardize_or_rescale_unit.sv -----
// ---------------------------------------------------------------------------
// label_standardize_or_rescale_unit
// Collects a set of Q16.16 labels and emits them standardised or rescaled.
// ---------------------------------------------------------------------------
//  Channel   Direction  Carries
//  s_*       in         one label word per handshake, tlast closes the set
//  m_*       out        one result word per stored label, tlast on the final one
//  APB       in/out     scale_mode (0x0), lower_bound (0x4), upper_bound (0x8)
//
//  A label word is taken whenever s_tvalid is high while the unit is loading. A word
//  with tlast starts the run, during which the input is stalled: a statistics
//  pass, a mean division, and in mode 0 a second pass, a variance division and
//  a square root. Each result then passes through the bit-serial divider,
//  which is skipped when the spread is zero.
//  Reset is synchronous and active low; the sample store needs no clearing.
//  A stalled result waits in the output register; the next set may start
//  loading as soon as the final result of a run sits there.
// ---------------------------------------------------------------------------
module label_standardize_or_rescale_unit import lsr_pkg::*; #(
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Input stream.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [DATA_W-1:0]      s_tdata,    // [31:0] label_value
    input  logic                   s_tlast,    // last_label
    // Result stream.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,    // [31:0] scaled_value, [37:32] result_index,
                                               // [69:38] data_mean, [100:70] data_spread
    output logic                   m_tlast,    // last_result
    output logic [STAT_W-1:0]      m_tuser,    // [1:0] status
    // Register port.
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    logic                     mode_reg;
    logic signed [DATA_W-1:0] lower_reg;
    logic signed [DATA_W-1:0] upper_reg;
    logic                     wr_en;
    logic [1:0]               reg_idx;
    lsr_cmd_t                 cmd;
    lsr_sts_t                 sts;

    // The register file: a write lands on the access cycle of the transfer.
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= 1'b0;
            lower_reg <= LOWER_RST;
            upper_reg <= UPPER_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_MODE:  mode_reg  <= pwdata[0];
                REG_LOWER: lower_reg <= signed'(pwdata);
                REG_UPPER: upper_reg <= signed'(pwdata);
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MODE:  prdata = {31'h0, mode_reg};
            REG_LOWER: prdata = lower_reg;
            REG_UPPER: prdata = upper_reg;
            default:   prdata = '0;
        endcase
    end

    // The sequencer steps the datapath through the load, the statistics passes
    // and the emission of one result per stored sample.
    lsr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    lsr_dp #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .mode     (mode_reg),
        .lower    (lower_reg),
        .upper    (upper_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );
endmodule
